// File: sv/fs3d_pkg.sv
// shared types, constants and helper functions for the volume shift and mask pipeline
package fs3d_pkg;

    localparam int unsigned CFG_ADDR_W = 5;
    localparam int unsigned CFG_DATA_W = 32;

    localparam int unsigned MAX_EDGE_DEFAULT = 256;

    localparam int unsigned GRID_W   = 9;
    localparam int unsigned COORD_W  = 8;
    localparam int unsigned VAL_W    = 32;
    localparam int unsigned INDEX_W  = 24;
    localparam int unsigned RADIUS_W = 16;
    localparam int unsigned MODE_W   = 2;

    localparam logic [GRID_W-1:0]   GRID_SIZE_RESET = 9'd256;
    localparam logic [RADIUS_W-1:0] RADIUS_SQ_RESET = 16'd49152;

    localparam logic [MODE_W-1:0] MODE_COMPLEX = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REAL    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MAG     = 2'd2;

    localparam logic [VAL_W-1:0] MAG_SAT = 32'h7FFF_FFFF;

    typedef enum logic [2:0] {
        REG_GRID_SIZE  = 3'd0,
        REG_SHIFT_DIR  = 3'd1,
        REG_VALUE_MODE = 3'd2,
        REG_MASK_EN    = 3'd3,
        REG_RADIUS_SQ  = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [VAL_W-1:0]   re;
        logic [VAL_W-1:0]   im;
        logic [VAL_W-1:0]   abs_re;
        logic [VAL_W-1:0]   abs_im;
        logic [63:0]        sq_re;
        logic [63:0]        sq_im;
        logic [63:0]        rad;
        logic [63:0]        root;
        logic signed [9:0]  diff_x;
        logic signed [9:0]  diff_y;
        logic signed [9:0]  diff_z;
        logic [15:0]        sq_x;
        logic [15:0]        sq_y;
        logic [15:0]        sq_z;
        logic [17:0]        dist_sq;
        logic [GRID_W-1:0]  rem_x;
        logic [GRID_W-1:0]  rem_y;
        logic [GRID_W-1:0]  rem_z;
        logic [17:0]        idx_xy;
        logic [INDEX_W-1:0] idx;
        logic               masked;
        logic [VAL_W-1:0]   res_re;
        logic [VAL_W-1:0]   res_im;
    } pipe_t;

    typedef struct packed {
        logic [63:0] rad;
        logic [63:0] root;
    } sqrt_t;

    // one restoring step of the remainder: subtract size << k where it fits
    function automatic logic [GRID_W-1:0] mod_step(
        input logic [GRID_W-1:0] rem,
        input logic [GRID_W-1:0] size,
        input int unsigned       k
    );
        logic [17:0] trial;
        logic [17:0] wide;
        trial = 18'(size) << k;
        wide  = 18'(rem);
        if (wide >= trial)
        begin
            wide = wide - trial;
        end
        return wide[GRID_W-1:0];
    endfunction

    // one digit of the floored square root, test bit at 4^(31-k)
    function automatic sqrt_t sqrt_step(
        input sqrt_t       s,
        input int unsigned k
    );
        sqrt_t       o;
        logic [63:0] test_bit;
        logic [63:0] trial;
        test_bit = 64'd1 << (62 - 2 * k);
        trial    = s.root + test_bit;
        if (s.rad >= trial)
        begin
            o.rad  = s.rad - trial;
            o.root = (s.root >> 1) + test_bit;
        end
        else
        begin
            o.rad  = s.rad;
            o.root = s.root >> 1;
        end
        return o;
    endfunction

endpackage

// File: sv/fftshift_3d_sphere_mask.sv
// top level: circular shift of voxel coordinates, spherical mask and value conversion
// throughput: one item per cycle unless stalled; 16-stage sqrt, two digits each, sets the depth
// bubbles collapse under output stall, so input is only stalled when all stages hold items
// reset: registers return to defaults, all pipeline valid bits clear; no clearing pass
module fftshift_3d_sphere_mask #(
    parameter int unsigned MAX_EDGE = fs3d_pkg::MAX_EDGE_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [fs3d_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [fs3d_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [fs3d_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready,

    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [fs3d_pkg::COORD_W-1:0]        src_x,
    input  logic [fs3d_pkg::COORD_W-1:0]        src_y,
    input  logic [fs3d_pkg::COORD_W-1:0]        src_z,
    input  logic signed [fs3d_pkg::VAL_W-1:0]   src_re,
    input  logic signed [fs3d_pkg::VAL_W-1:0]   src_im,

    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [fs3d_pkg::INDEX_W-1:0]        dest_index,
    output logic signed [fs3d_pkg::VAL_W-1:0]   out_re,
    output logic signed [fs3d_pkg::VAL_W-1:0]   out_im
);

    import fs3d_pkg::*;

    localparam int unsigned MOD_BITS       = GRID_W;
    localparam int unsigned MOD_PER_STAGE  = 3;
    localparam int unsigned MOD_FIRST      = 1;
    localparam int unsigned MOD_STAGES     = MOD_BITS / MOD_PER_STAGE;
    localparam int unsigned SQUARE_STAGE   = 1;
    localparam int unsigned SUM_STAGE      = 2;
    localparam int unsigned MASK_STAGE     = 3;
    localparam int unsigned IDX_XY_STAGE   = 4;
    localparam int unsigned IDX_STAGE      = 5;
    localparam int unsigned SQRT_STEPS     = 32;
    localparam int unsigned SQRT_PER_STAGE = 2;
    localparam int unsigned SQRT_FIRST     = 3;
    localparam int unsigned SQRT_STAGES    = SQRT_STEPS / SQRT_PER_STAGE;
    localparam int unsigned OUT_STAGE      = SQRT_FIRST + SQRT_STAGES;
    localparam int unsigned DEPTH          = OUT_STAGE + 1;

    // configuration registers
    logic [GRID_W-1:0]   grid_size_reg, grid_size_next;
    logic                shift_dir_reg, shift_dir_next;
    logic [MODE_W-1:0]   value_mode_reg, value_mode_next;
    logic                mask_en_reg, mask_en_next;
    logic [RADIUS_W-1:0] radius_sq_reg, radius_sq_next;

    logic                cfg_write;
    logic [2:0]          cfg_index;

    logic [GRID_W-1:0]   size_eff;
    logic [COORD_W-1:0]  centre;
    logic [GRID_W-1:0]   offset;

    pipe_t               pipe_reg  [DEPTH];
    pipe_t               pipe_next [DEPTH];
    logic [DEPTH-1:0]    valid_reg;
    logic [DEPTH-1:0]    valid_next;
    logic [DEPTH-1:0]    stage_en;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[CFG_ADDR_W-1:2];

    always_comb
    begin
        grid_size_next  = grid_size_reg;
        shift_dir_next  = shift_dir_reg;
        value_mode_next = value_mode_reg;
        mask_en_next    = mask_en_reg;
        radius_sq_next  = radius_sq_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_GRID_SIZE:  grid_size_next  = pwdata[GRID_W-1:0];
                REG_SHIFT_DIR:  shift_dir_next  = pwdata[0];
                REG_VALUE_MODE: value_mode_next = pwdata[MODE_W-1:0];
                REG_MASK_EN:    mask_en_next    = pwdata[0];
                REG_RADIUS_SQ:  radius_sq_next  = pwdata[RADIUS_W-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_size_reg  <= GRID_SIZE_RESET;
            shift_dir_reg  <= 1'b0;
            value_mode_reg <= MODE_COMPLEX;
            mask_en_reg    <= 1'b0;
            radius_sq_reg  <= RADIUS_SQ_RESET;
        end
        else
        begin
            grid_size_reg  <= grid_size_next;
            shift_dir_reg  <= shift_dir_next;
            value_mode_reg <= value_mode_next;
            mask_en_reg    <= mask_en_next;
            radius_sq_reg  <= radius_sq_next;
        end
    end

    always_comb
    begin
        case (cfg_index)
            REG_GRID_SIZE:  prdata = CFG_DATA_W'(grid_size_reg);
            REG_SHIFT_DIR:  prdata = CFG_DATA_W'(shift_dir_reg);
            REG_VALUE_MODE: prdata = CFG_DATA_W'(value_mode_reg);
            REG_MASK_EN:    prdata = CFG_DATA_W'(mask_en_reg);
            REG_RADIUS_SQ:  prdata = CFG_DATA_W'(radius_sq_reg);
            default:        prdata = '0;
        endcase
    end

    // zero size acts as one, oversize clamps to the largest edge
    always_comb
    begin
        if (grid_size_reg == '0)
        begin
            size_eff = GRID_W'(1);
        end
        else if (32'(grid_size_reg) > 32'(MAX_EDGE))
        begin
            size_eff = GRID_W'(MAX_EDGE);
        end
        else
        begin
            size_eff = grid_size_reg;
        end
        centre = size_eff[GRID_W-1:1];
        offset = shift_dir_reg ? GRID_W'(centre) : GRID_W'(centre) + GRID_W'(1);
    end

    // a stage moves when it is empty or some later stage can make room
    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_en
            assign stage_en[i] = !out_stall || !(&valid_reg[DEPTH-1:i]);
        end
    endgenerate

    assign in_stall = !stage_en[0];

    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_stage
            if (i == 0)
            begin : g_first
                always_comb
                begin
                    pipe_next[i]        = '0;
                    valid_next[i]       = in_valid;
                    pipe_next[i].re     = unsigned'(src_re);
                    pipe_next[i].im     = unsigned'(src_im);
                    pipe_next[i].abs_re = src_re[VAL_W-1] ? unsigned'(~src_re) + 32'd1
                                                          : unsigned'(src_re);
                    pipe_next[i].abs_im = src_im[VAL_W-1] ? unsigned'(~src_im) + 32'd1
                                                          : unsigned'(src_im);
                    pipe_next[i].diff_x = $signed({2'b00, src_x}) - $signed({2'b00, centre});
                    pipe_next[i].diff_y = $signed({2'b00, src_y}) - $signed({2'b00, centre});
                    pipe_next[i].diff_z = $signed({2'b00, src_z}) - $signed({2'b00, centre});
                    pipe_next[i].rem_x  = GRID_W'(src_x) + offset;
                    pipe_next[i].rem_y  = GRID_W'(src_y) + offset;
                    pipe_next[i].rem_z  = GRID_W'(src_z) + offset;
                end
            end
            else
            begin : g_rest
                always_comb
                begin
                    sqrt_t s;
                    pipe_next[i]  = pipe_reg[i-1];
                    valid_next[i] = valid_reg[i-1];

                    if (i == SQUARE_STAGE)
                    begin
                        pipe_next[i].sq_re = 64'(pipe_reg[i-1].abs_re) * 64'(pipe_reg[i-1].abs_re);
                        pipe_next[i].sq_im = 64'(pipe_reg[i-1].abs_im) * 64'(pipe_reg[i-1].abs_im);
                        pipe_next[i].sq_x  = 16'(20'(pipe_reg[i-1].diff_x)
                                                 * 20'(pipe_reg[i-1].diff_x));
                        pipe_next[i].sq_y  = 16'(20'(pipe_reg[i-1].diff_y)
                                                 * 20'(pipe_reg[i-1].diff_y));
                        pipe_next[i].sq_z  = 16'(20'(pipe_reg[i-1].diff_z)
                                                 * 20'(pipe_reg[i-1].diff_z));
                    end

                    if (i == SUM_STAGE)
                    begin
                        pipe_next[i].rad     = pipe_reg[i-1].sq_re + pipe_reg[i-1].sq_im;
                        pipe_next[i].root    = '0;
                        pipe_next[i].dist_sq = 18'(pipe_reg[i-1].sq_x) + 18'(pipe_reg[i-1].sq_y)
                                             + 18'(pipe_reg[i-1].sq_z);
                    end

                    if (i >= MOD_FIRST && i < MOD_FIRST + MOD_STAGES)
                    begin
                        for (int j = 0; j < MOD_PER_STAGE; j++)
                        begin
                            pipe_next[i].rem_x = mod_step(pipe_next[i].rem_x, size_eff,
                                MOD_BITS - 1 - (i - MOD_FIRST) * MOD_PER_STAGE - j);
                            pipe_next[i].rem_y = mod_step(pipe_next[i].rem_y, size_eff,
                                MOD_BITS - 1 - (i - MOD_FIRST) * MOD_PER_STAGE - j);
                            pipe_next[i].rem_z = mod_step(pipe_next[i].rem_z, size_eff,
                                MOD_BITS - 1 - (i - MOD_FIRST) * MOD_PER_STAGE - j);
                        end
                    end

                    if (i == MASK_STAGE)
                    begin
                        pipe_next[i].masked = mask_en_reg
                                           && (pipe_reg[i-1].dist_sq > 18'(radius_sq_reg));
                    end

                    if (i == IDX_XY_STAGE)
                    begin
                        pipe_next[i].idx_xy = 18'(pipe_reg[i-1].rem_x) * 18'(size_eff)
                                            + 18'(pipe_reg[i-1].rem_y);
                    end

                    if (i == IDX_STAGE)
                    begin
                        pipe_next[i].idx = INDEX_W'(27'(pipe_reg[i-1].idx_xy) * 27'(size_eff)
                                                    + 27'(pipe_reg[i-1].rem_z));
                    end

                    if (i >= SQRT_FIRST && i < SQRT_FIRST + SQRT_STAGES)
                    begin
                        s.rad  = pipe_reg[i-1].rad;
                        s.root = pipe_reg[i-1].root;
                        for (int j = 0; j < SQRT_PER_STAGE; j++)
                        begin
                            s = sqrt_step(s, (i - SQRT_FIRST) * SQRT_PER_STAGE + j);
                        end
                        pipe_next[i].rad  = s.rad;
                        pipe_next[i].root = s.root;
                    end

                    if (i == OUT_STAGE)
                    begin
                        if (pipe_reg[i-1].masked)
                        begin
                            pipe_next[i].res_re = '0;
                            pipe_next[i].res_im = '0;
                        end
                        else
                        begin
                            case (value_mode_reg)
                                MODE_COMPLEX:
                                begin
                                    pipe_next[i].res_re = pipe_reg[i-1].re;
                                    pipe_next[i].res_im = pipe_reg[i-1].im;
                                end
                                MODE_MAG:
                                begin
                                    pipe_next[i].res_re =
                                        (pipe_reg[i-1].root > 64'(MAG_SAT)) ? MAG_SAT
                                                                : pipe_reg[i-1].root[VAL_W-1:0];
                                    pipe_next[i].res_im = '0;
                                end
                                default:
                                begin
                                    pipe_next[i].res_re = pipe_reg[i-1].re;
                                    pipe_next[i].res_im = '0;
                                end
                            endcase
                        end
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[i] <= 1'b0;
                end
                else if (stage_en[i])
                begin
                    valid_reg[i] <= valid_next[i];
                end
            end

            always_ff @(posedge clk)
            begin
                if (stage_en[i])
                begin
                    pipe_reg[i] <= pipe_next[i];
                end
            end
        end
    endgenerate

    assign out_valid  = valid_reg[DEPTH-1];
    assign dest_index = pipe_reg[DEPTH-1].idx;
    assign out_re     = signed'(pipe_reg[DEPTH-1].res_re);
    assign out_im     = signed'(pipe_reg[DEPTH-1].res_im);

endmodule

// File: sv/fs3d_checker.sv
// port-level assertions for the volume shift and mask block, bound to the top level
module fs3d_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [fs3d_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [fs3d_pkg::CFG_DATA_W-1:0]     pwdata,
    input  logic [fs3d_pkg::CFG_DATA_W-1:0]     prdata,
    input  logic                                pready,
    input  logic                                in_stall,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic [fs3d_pkg::INDEX_W-1:0]        dest_index,
    input  logic signed [fs3d_pkg::VAL_W-1:0]   out_re,
    input  logic signed [fs3d_pkg::VAL_W-1:0]   out_im
);

    import fs3d_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] GRID_ADDR = CFG_ADDR_W'(REG_GRID_SIZE) << 2;
    localparam logic [CFG_ADDR_W-1:0] MODE_ADDR = CFG_ADDR_W'(REG_VALUE_MODE) << 2;

    // a free output never backs up the input
    a_no_stall_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("input stalled while output free");

    // a held result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(dest_index)
                                   && $stable(out_re) && $stable(out_im))
        else $error("stalled result changed");

    // grid size reads back what was written, trimmed to its width
    a_grid_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && paddr == GRID_ADDR)
        ##1 (psel && !pwrite && paddr == GRID_ADDR)
        |-> prdata[GRID_W-1:0] == $past(pwdata[GRID_W-1:0])
            && prdata[CFG_DATA_W-1:GRID_W] == '0)
        else $error("grid size readback mismatch");

    // value mode reads back what was written
    a_mode_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && paddr == MODE_ADDR)
        ##1 (psel && !pwrite && paddr == MODE_ADDR)
        |-> prdata[MODE_W-1:0] == $past(pwdata[MODE_W-1:0])
            && prdata[CFG_DATA_W-1:MODE_W] == '0)
        else $error("value mode readback mismatch");

endmodule

bind fftshift_3d_sphere_mask fs3d_checker u_fs3d_checker (.*);

// File: tb/fftshift_3d_sphere_mask_tb.sv
// self-checking testbench for the volume shift and sphere mask pipeline
module fftshift_3d_sphere_mask_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fs3d_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned REPORT_MAX = 10;
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam logic DIR_CENTRE_TO_ORIGIN = 1'b0;
    localparam logic DIR_ORIGIN_TO_CENTRE = 1'b1;

    typedef struct packed {
        logic [COORD_W-1:0]       x;
        logic [COORD_W-1:0]       y;
        logic [COORD_W-1:0]       z;
        logic signed [VAL_W-1:0]  re;
        logic signed [VAL_W-1:0]  im;
    } voxel_t;

    typedef struct packed {
        logic [INDEX_W-1:0]       index;
        logic signed [VAL_W-1:0]  re;
        logic signed [VAL_W-1:0]  im;
    } shifted_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0]      paddr = '0;
    logic [CFG_DATA_W-1:0]      pwdata = '0;
    logic [CFG_DATA_W-1:0]      prdata;
    logic                       pready;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic [COORD_W-1:0]         src_x = '0;
    logic [COORD_W-1:0]         src_y = '0;
    logic [COORD_W-1:0]         src_z = '0;
    logic signed [VAL_W-1:0]    src_re = '0;
    logic signed [VAL_W-1:0]    src_im = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [INDEX_W-1:0]         dest_index;
    logic signed [VAL_W-1:0]    out_re;
    logic signed [VAL_W-1:0]    out_im;

    logic [GRID_W-1:0]          cfg_grid = GRID_SIZE_RESET;
    logic                       cfg_dir = DIR_CENTRE_TO_ORIGIN;
    logic [MODE_W-1:0]          cfg_mode = MODE_COMPLEX;
    logic                       cfg_mask = 1'b0;
    logic [RADIUS_W-1:0]        cfg_radius = RADIUS_SQ_RESET;

    voxel_t                     voxel_q[$];
    shifted_t                   shifted_q[$];
    voxel_t                     queued_voxel;
    shifted_t                   due;
    int unsigned                send_idle_pct = 0;
    int unsigned                stall_pct = 0;
    logic                       hold_on = 1'b0;
    int unsigned                hold_count = 0;
    int unsigned                mismatches = 0;
    int unsigned                cycles = 0;

    fftshift_3d_sphere_mask dut (.*);

    always #5 clk = ~clk;

    function automatic int unsigned edge_len();
        int unsigned size;
        size = cfg_grid;
        if (size < 1)
            size = 1;
        if (size > MAX_EDGE_DEFAULT)
            size = MAX_EDGE_DEFAULT;
        return size;
    endfunction

    // floored root by testing one result bit at a time
    function automatic longint unsigned floor_root(input longint unsigned n);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int k = 31; k >= 0; k--)
        begin
            trial = root | (64'd1 << k);
            if (trial * trial <= n)
                root = trial;
        end
        return root;
    endfunction

    function automatic shifted_t shift_voxel(input voxel_t v);
        shifted_t        r;
        int unsigned     size;
        int unsigned     half;
        int unsigned     off;
        int unsigned     sx;
        int unsigned     sy;
        int unsigned     sz;
        int              radial_sq;
        longint unsigned lin;
        longint signed   a_re;
        longint signed   a_im;
        longint unsigned mag;
        size = edge_len();
        half = size / 2;
        off = (cfg_dir == DIR_ORIGIN_TO_CENTRE) ? half : half + 1;
        sx = (v.x + off) % size;
        sy = (v.y + off) % size;
        sz = (v.z + off) % size;
        lin = (longint'(sx) * size + sy) * size + sz;
        r.index = lin[INDEX_W-1:0];
        radial_sq = (int'(v.x) - int'(half)) ** 2 + (int'(v.y) - int'(half)) ** 2
                  + (int'(v.z) - int'(half)) ** 2;
        if (cfg_mask && radial_sq > int'(cfg_radius))
        begin
            r.re = '0;
            r.im = '0;
        end
        else if (cfg_mode == MODE_COMPLEX)
        begin
            r.re = v.re;
            r.im = v.im;
        end
        else if (cfg_mode == MODE_MAG)
        begin
            a_re = v.re;
            a_im = v.im;
            if (a_re < 0)
                a_re = -a_re;
            if (a_im < 0)
                a_im = -a_im;
            mag = floor_root(longint'(unsigned'(a_re * a_re))
                           + longint'(unsigned'(a_im * a_im)));
            r.re = (mag > MAG_SAT) ? MAG_SAT : mag[VAL_W-1:0];
            r.im = '0;
        end
        else
        begin
            r.re = v.re;
            r.im = '0;
        end
        return r;
    endfunction

    task automatic write_reg(input cfg_reg_t which, input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {which, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (which)
            REG_GRID_SIZE:  cfg_grid = value[GRID_W-1:0];
            REG_SHIFT_DIR:  cfg_dir = value[0];
            REG_VALUE_MODE: cfg_mode = value[MODE_W-1:0];
            REG_MASK_EN:    cfg_mask = value[0];
            REG_RADIUS_SQ:  cfg_radius = value[RADIUS_W-1:0];
            default:        ;
        endcase
    endtask

    task automatic configure(input int unsigned grid, input logic dir,
                             input logic [MODE_W-1:0] mode, input logic mask,
                             input int unsigned radius);
        write_reg(REG_GRID_SIZE, grid);
        write_reg(REG_SHIFT_DIR, CFG_DATA_W'(dir));
        write_reg(REG_VALUE_MODE, CFG_DATA_W'(mode));
        write_reg(REG_MASK_EN, CFG_DATA_W'(mask));
        write_reg(REG_RADIUS_SQ, radius);
    endtask

    task automatic add_voxel(input int unsigned x, input int unsigned y, input int unsigned z,
                             input logic [VAL_W-1:0] re, input logic [VAL_W-1:0] im);
        voxel_q.push_back(voxel_t'{x[COORD_W-1:0], y[COORD_W-1:0], z[COORD_W-1:0], re, im});
    endtask

    function automatic logic [VAL_W-1:0] random_value();
        case ($urandom_range(7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return $urandom_range(65535) << $urandom_range(16);
            default: return $urandom;
        endcase
    endfunction

    function automatic int unsigned random_coord();
        if ($urandom_range(3) == 0)
            return $urandom_range(255);
        return $urandom_range(edge_len() - 1);
    endfunction

    task automatic add_random_voxels(input int unsigned count);
        repeat (count)
            add_voxel(random_coord(), random_coord(), random_coord(),
                      random_value(), random_value());
    endtask

    task automatic wait_idle();
        while (voxel_q.size() != 0 || in_valid || shifted_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic report_mismatch(input shifted_t want, input shifted_t got);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("mismatch at %0t: index exp %h got %h, re exp %h got %h, im exp %h got %h",
                     $realtime, want.index, got.index, want.re, got.re, want.im, got.im);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            src_x <= '0;
            src_y <= '0;
            src_z <= '0;
            src_re <= '0;
            src_im <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
                shifted_q.push_back(shift_voxel(voxel_t'{src_x, src_y, src_z, src_re, src_im}));
            if (!in_valid || !in_stall)
            begin
                if (voxel_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    queued_voxel = voxel_q.pop_front();
                    src_x <= queued_voxel.x;
                    src_y <= queued_voxel.y;
                    src_z <= queued_voxel.z;
                    src_re <= queued_voxel.re;
                    src_im <= queued_voxel.im;
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall, with one long hold-off when requested
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_count <= 0;
        end
        else if (hold_on && hold_count < HOLD_CYCLES)
        begin
            out_stall <= 1'b1;
            hold_count <= hold_count + 1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (shifted_q.size() == 0)
            begin
                report_mismatch('0, shifted_t'{dest_index, out_re, out_im});
            end
            else
            begin
                due = shifted_q.pop_front();
                if (dest_index !== due.index || out_re !== due.re || out_im !== due.im)
                    report_mismatch(due, shifted_t'{dest_index, out_re, out_im});
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        int unsigned half;
        int unsigned idle_kind;
        int unsigned grids[10];
        grids = '{1, 2, 3, 0, 511, 256, 16, 300, 7, 64};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // corners, centre and value extremes at reset settings
        add_voxel(0, 0, 0, 32'h0000_0000, 32'h0000_0000);
        add_voxel(255, 255, 255, 32'h7FFF_FFFF, 32'h8000_0000);
        add_voxel(128, 128, 128, 32'h8000_0000, 32'h7FFF_FFFF);
        add_voxel(127, 0, 255, 32'hFFFF_FFFF, 32'h0000_0001);
        add_voxel(255, 0, 127, 32'h0001_0000, 32'hFFFF_0000);
        add_voxel(0, 255, 129, 32'hAAAA_5555, 32'h5555_AAAA);
        wait_idle();

        // magnitude with the mask on a small grid
        configure(8, DIR_ORIGIN_TO_CENTRE, MODE_MAG, 1'b1, 12);
        add_voxel(4, 4, 4, 32'h8000_0000, 32'h8000_0000);
        add_voxel(3, 4, 4, 32'h0003_0000, 32'hFFFC_0000);
        add_voxel(2, 2, 2, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_voxel(1, 4, 2, 32'h0001_0000, 32'h0001_0000);
        add_voxel(200, 4, 4, 32'h0001_0000, 32'h0000_0000);
        add_voxel(7, 7, 7, 32'h0000_0000, 32'h0000_0000);
        add_voxel(4, 4, 4, 32'hFFFF_FFFF, 32'h0000_0000);
        wait_idle();

        // oversized grid with real part only
        configure(511, DIR_CENTRE_TO_ORIGIN, MODE_REAL, 1'b0, 65535);
        add_voxel(255, 255, 255, 32'h8000_0000, 32'h7FFF_FFFF);
        add_voxel(0, 127, 128, 32'h1234_5678, 32'h9ABC_DEF0);
        wait_idle();

        // zero grid, spare value mode, radius zero
        configure(0, DIR_ORIGIN_TO_CENTRE, MODE_SPARE, 1'b1, 0);
        add_voxel(0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF);
        add_voxel(1, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000);
        add_voxel(255, 255, 255, 32'h0F0F_0F0F, 32'hF0F0_F0F0);
        wait_idle();

        for (int k = 0; k < 10; k++)
        begin
            write_reg(REG_GRID_SIZE, grids[k]);
            half = edge_len() / 2;
            configure(grids[k], 1'(k % 2), MODE_W'(k % 4), (k % 3) != 0,
                      (k == 1) ? 0 : (k == 4) ? 65535 : $urandom_range(3 * half * half + 2 * half));
            idle_kind = (k + 2 * (k / 4)) % 4;
            send_idle_pct = (idle_kind == 1) ? 88 : (idle_kind == 3) ? 20 : 0;
            stall_pct = (idle_kind == 2) ? 88 : (idle_kind == 3) ? 20 : 0;
            add_random_voxels(50);
            wait_idle();
        end

        // long receiver hold-off while the sender keeps offering
        configure(256, DIR_CENTRE_TO_ORIGIN, MODE_MAG, 1'b1, 49152);
        send_idle_pct = 0;
        stall_pct = 0;
        hold_on = 1'b1;
        add_random_voxels(60);
        wait_idle();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && shifted_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
